FILE: src/vaim_pkg.sv
// ----------------------------------------------------------------------------
// Virtual analog input mapper: shared types and constants
// Source kinds, operation codes, datapath widths and the handshake structs
// between the sequencer and the serial divider.
// ----------------------------------------------------------------------------
package vaim_pkg;

	typedef enum logic [0:0] {
		OP_READ = 1'b0,
		OP_TICK = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		KIND_NONE         = 3'd0,
		KIND_CONSTANT     = 3'd1,
		KIND_SWITCH       = 3'd2,
		KIND_AXIS         = 3'd3,
		KIND_KEY_SLIDER   = 3'd4,
		KIND_AXIS_SLIDER  = 3'd5
	} source_kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_RESULT,
		ST_MUL,
		ST_PREP,
		ST_DIV,
		ST_WRITE
	} state_t;

	localparam int POS_W    = 16;
	localparam int AXIS_W   = 18;
	localparam int SPEED_W  = 16;
	localparam int DIR_W    = 11;
	localparam int PROD_W   = 28;
	localparam int STEP_W   = 20;
	localparam int CTR_W    = 17;
	localparam int CPROD_W  = 26;
	localparam int DIV_W    = 23;
	localparam int DVSR_W   = 8;

	localparam logic [POS_W-1:0] POS_CENTER = 16'h8000;
	localparam logic [POS_W-1:0] POS_MIN    = 16'h0100;
	localparam logic [POS_W-1:0] POS_MAX    = 16'hff00;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    dividend;
		logic [DVSR_W-1:0]   divisor;
	} div_req_t;

	typedef struct packed {
		logic                done;
		logic [DIV_W-1:0]    quotient;
	} div_rsp_t;

endpackage

FILE: src/vaim_divider.sv
// ----------------------------------------------------------------------------
// Serial divider
// Restoring unsigned division, one quotient bit per cycle. Used for the
// centering pull of the slider position.
// ----------------------------------------------------------------------------
module vaim_divider
	import vaim_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int CNT_W = $clog2(DIV_W);

	logic [DIV_W-1:0]  dv_q;
	logic [DVSR_W-1:0] rem_q;
	logic [DVSR_W-1:0] divisor_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;

	logic [DVSR_W:0]   trial;
	logic [DVSR_W:0]   diff;
	logic              ge;

	assign trial = {rem_q, dv_q[DIV_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign ge    = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_W - 1);
			end else if (busy_q) begin
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dv_q      <= req.dividend;
			divisor_q <= req.divisor;
			rem_q     <= '0;
		end else if (busy_q) begin
			dv_q  <= {dv_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = dv_q;

endmodule

FILE: src/vaim_slider_ram.sv
// ----------------------------------------------------------------------------
// Slider position store
// One 16-bit position per slot with a registered read port. Entries never
// written read as the center position.
// ----------------------------------------------------------------------------
module vaim_slider_ram
	import vaim_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_addr,
	output logic [POS_W-1:0]                      rd_data,
	input  logic                                  wr_en,
	input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_addr,
	input  logic [POS_W-1:0]                      wr_data
);

	logic [POS_W-1:0] mem_q [SLOTS];
	logic [SLOTS-1:0] vld_q;
	logic [POS_W-1:0] rd_q;
	logic             rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			rd_vld_q <= vld_q[rd_addr];
		end
	end

	assign rd_data = rd_vld_q ? rd_q : POS_CENTER;

endmodule

FILE: src/virtual_analog_input_mapper.sv
// ----------------------------------------------------------------------------
// Virtual analog input mapper
// Turns one controller source into an emulated input byte and keeps one
// virtual slider position per slot.
// ----------------------------------------------------------------------------
// A read request loads its word into the output register once that register
// is free. A tick request returns nothing; when centering is on it waits on
// the bit-serial divider that scales the pull toward the center. The block
// takes one request at a time, while a finished read word may still wait in
// the output register.
// After reset every slider stands at the center position 0x8000.
module virtual_analog_input_mapper
	import vaim_pkg::*;
#(
	parameter int SLOTS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// slot[4:0], analog_switch[5], constant_value[13:6], switch_pressed[14],
	// key_decrease[15], key_increase[16], axis_value[34:17],
	// slider_speed[50:35], center_strength[58:51], input_enabled[59], zeros
	input  logic [63:0] s_tdata,
	// opcode[0], source_kind[3:1]
	input  logic [3:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// output_value[7:0]
	output logic [7:0]  m_tdata
);

	localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

	state_t state_q, state_d;

	// Captured request
	opcode_t             op_q;
	source_kind_t        kind_q;
	logic [IW-1:0]       addr_q;
	logic                slot_ok_q;
	logic                analog_q;
	logic [7:0]          const_q;
	logic                pressed_q;
	logic                dec_q;
	logic                inc_q;
	logic signed [AXIS_W-1:0] axis_q;
	logic [SPEED_W-1:0]  speed_q;
	logic [7:0]          center_q;
	logic                en_q;

	logic [8:0]          slot_ext;

	// Tick datapath
	logic signed [PROD_W-1:0]  prod_step_q;
	logic signed [CPROD_W-1:0] prod_ctr_q;
	logic signed [CTR_W-1:0]   v_q;
	logic signed [STEP_W-1:0]  step_q;
	logic                      neg_q;

	logic                out_valid_q;
	logic [7:0]          out_data_q;

	logic [POS_W-1:0]    pos;
	logic                wr_en;
	logic [POS_W-1:0]    wr_data;
	logic                accept;
	logic                load_out;
	logic                tick_ok;

	div_req_t            div_req;
	div_rsp_t            div_rsp;

	logic signed [AXIS_W-1:0]  ax;
	logic signed [AXIS_W:0]    ax_r9;
	logic signed [AXIS_W:0]    ax_r8;
	logic signed [9:0]         ax_div;
	logic signed [10:0]        ax_off;
	logic signed [DIR_W-1:0]   dir;
	logic                      sw_on;
	logic [7:0]                read_val;

	logic signed [PROD_W-1:0]  step_adj;
	logic signed [CPROD_W-1:0] ctr_abs;
	logic signed [CTR_W:0]     q_mag;
	logic signed [CTR_W:0]     q_val;
	logic signed [20:0]        sum;

	assign slot_ext = {4'b0, s_tdata[4:0]};
	assign accept   = s_tvalid && s_tready;
	assign tick_ok  = slot_ok_q && (kind_q inside {KIND_KEY_SLIDER, KIND_AXIS_SLIDER});

	// ---------------- Sequencer ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d          = state_q;
		s_tready         = 1'b0;
		load_out         = 1'b0;
		div_req.start    = 1'b0;
		div_req.dividend = ctr_abs[DIV_W-1:0];
		div_req.divisor  = center_q;
		wr_en            = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (op_q == OP_READ) begin
					state_d = ST_RESULT;
				end else if (tick_ok) begin
					state_d = ST_MUL;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_RESULT: begin
				if (!out_valid_q || m_tready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			ST_MUL: begin
				state_d = ST_PREP;
			end
			ST_PREP: begin
				if (center_q != 8'd0) begin
					div_req.start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					state_d = ST_WRITE;
				end
			end
			ST_DIV: begin
				if (div_rsp.done) begin
					state_d = ST_WRITE;
				end
			end
			ST_WRITE: begin
				wr_en   = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// ---------------- Request capture ----------------
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q      <= opcode_t'(s_tuser[0]);
			kind_q    <= source_kind_t'(s_tuser[3:1]);
			addr_q    <= slot_ext[IW-1:0];
			slot_ok_q <= slot_ext < 9'(SLOTS);
			analog_q  <= s_tdata[5];
			const_q   <= s_tdata[13:6];
			pressed_q <= s_tdata[14];
			dec_q     <= s_tdata[15];
			inc_q     <= s_tdata[16];
			axis_q    <= s_tdata[34:17];
			speed_q   <= s_tdata[50:35];
			center_q  <= s_tdata[58:51];
			en_q      <= s_tdata[59];
		end
	end

	vaim_slider_ram #(
		.SLOTS(SLOTS)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (addr_q),
		.rd_data (pos),
		.wr_en   (wr_en),
		.wr_addr (addr_q),
		.wr_data (wr_data)
	);

	// ---------------- Read mapping ----------------
	// Signed division by a power of two truncates toward zero: bias negative
	// values before the arithmetic shift.
	assign ax     = en_q ? axis_q : '0;
	assign ax_r9  = {ax[AXIS_W-1], ax} + (ax[AXIS_W-1] ? 19'sd511 : 19'sd0);
	assign ax_r8  = {ax[AXIS_W-1], ax} + (ax[AXIS_W-1] ? 19'sd255 : 19'sd0);
	assign ax_div = ax_r9[AXIS_W:9];
	assign ax_off = {ax_div[9], ax_div} + 11'sd128;
	assign sw_on  = en_q && pressed_q;

	always_comb begin
		case (kind_q) inside
			KIND_CONSTANT: read_val = const_q;
			KIND_SWITCH: begin
				if (analog_q) begin
					read_val = sw_on ? 8'hff : 8'h01;
				end else begin
					read_val = {7'b0, sw_on};
				end
			end
			KIND_AXIS: begin
				if (ax_off < 11'sd1) begin
					read_val = 8'h01;
				end else if (ax_off > 11'sd255) begin
					read_val = 8'hff;
				end else begin
					read_val = ax_off[7:0];
				end
			end
			KIND_KEY_SLIDER, KIND_AXIS_SLIDER: begin
				read_val = slot_ok_q ? pos[15:8] : 8'h00;
			end
			default: read_val = 8'h00;
		endcase
	end

	// ---------------- Tick datapath ----------------
	always_comb begin
		if (kind_q == KIND_KEY_SLIDER) begin
			dir = ((en_q && inc_q) ? 11'sd256 : 11'sd0) -
				((en_q && dec_q) ? 11'sd256 : 11'sd0);
		end else begin
			dir = ax_r8[AXIS_W:8];
		end
	end

	assign step_adj = prod_step_q + (prod_step_q[PROD_W-1] ? 28'sd255 : 28'sd0);
	assign ctr_abs  = prod_ctr_q[CPROD_W-1] ? -prod_ctr_q : prod_ctr_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_MUL) begin
			prod_step_q <= dir * $signed({1'b0, speed_q});
			v_q         <= $signed({1'b0, pos}) - $signed({1'b0, POS_CENTER});
			prod_ctr_q  <= ($signed({1'b0, pos}) - $signed({1'b0, POS_CENTER})) *
				$signed({1'b0, center_q - 8'd1});
		end
		if (state_q == ST_PREP) begin
			step_q <= step_adj[PROD_W-1:8];
			neg_q  <= prod_ctr_q[CPROD_W-1];
		end
	end

	vaim_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// The centered offset never exceeds the center distance, so 17 bits of
	// the quotient carry its magnitude.
	assign q_mag = $signed({1'b0, div_rsp.quotient[CTR_W-1:0]});
	always_comb begin
		if (center_q == 8'd0) begin
			q_val = {v_q[CTR_W-1], v_q};
		end else begin
			q_val = neg_q ? -q_mag : q_mag;
		end
	end

	assign sum = {{3{q_val[CTR_W]}}, q_val} + 21'sd32768 +
		{step_q[STEP_W-1], step_q};

	always_comb begin
		if (sum < $signed({5'b0, POS_MIN})) begin
			wr_data = POS_MIN;
		end else if (sum > $signed({5'b0, POS_MAX})) begin
			wr_data = POS_MAX;
		end else begin
			wr_data = sum[POS_W-1:0];
		end
	end

	// ---------------- Output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= read_val;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// ---------------- Assertions ----------------
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> state_q == ST_DIV)
		else $error("divider finished outside the divide state");

	a_write_only_slider: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (op_q == OP_TICK) && tick_ok)
		else $error("slider write for a request that is not a slider tick");

	a_write_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_data >= POS_MIN) && (wr_data <= POS_MAX))
		else $error("slider position written outside its clamp range");

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		load_out |-> op_q == OP_READ)
		else $error("result word produced for a tick request");

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_LOAD)
		else $error("accepted request did not start the sequencer");

endmodule
